/* rtl/wsfd_pkg.sv */
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	// opcodes with a flag of their own
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	// 7-bit length codes that announce an extended length
	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	// decoupling queue between parser and output stage
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// one classified item, as the parser hands it to the output stage
	typedef struct packed {
		logic [7:0]  data;
		logic [7:0]  key;
		logic        has_byte;
		logic        eof;
		logic        fin;
		logic [3:0]  opcode;
		logic [63:0] length;
		logic [3:0]  hdr_len;
	} item_t;

endpackage

/* rtl/wsfd_front.sv */
// ----------------------------------------------------------------------------
// wsfd_front
// Header parser: walks the frame header, keeps the frame state and sorts each
// byte into header (dropped), payload byte or empty-frame marker.
// ----------------------------------------------------------------------------
module wsfd_front #(
	parameter int LENGTH_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          in_byte,
	input  logic                restart,
	input  logic                q_full,
	output logic                q_push,
	output wsfd_pkg::item_t     q_item
);

	localparam logic [2:0] PH_HDR0 = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_KEY  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	logic [2:0]             phase_q, phase_d, ph;
	logic [2:0]             cnt_q, cnt_d;
	logic [3:0]             opcode_q, opcode_d;
	logic                   fin_q, fin_d;
	logic                   masked_q, masked_d;
	logic                   ext8_q, ext8_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;
	logic [31:0]            key_q, key_d;
	logic [1:0]             pos_q, pos_d;
	logic [3:0]             htot_q, htot_d;

	logic       accept;
	logic       emit, do_after, do_hd;
	logic       e_has, e_eof;
	logic [7:0] e_data, e_key;
	logic       hdr_mask;
	logic [6:0] len_code;

	assign accept   = push & ~q_full;
	assign hdr_mask = in_byte[7];
	assign len_code = in_byte[6:0];

	always_comb begin
		ph       = restart ? PH_HDR0 : phase_q;
		phase_d  = ph;
		cnt_d    = cnt_q;
		opcode_d = opcode_q;
		fin_d    = fin_q;
		masked_d = masked_q;
		ext8_d   = ext8_q;
		len_d    = len_q;
		rem_d    = rem_q;
		key_d    = key_q;
		pos_d    = pos_q;
		htot_d   = htot_q;
		emit     = 1'b0;
		do_after = 1'b0;
		do_hd    = 1'b0;
		e_has    = 1'b0;
		e_eof    = 1'b0;
		e_data   = 8'h00;
		e_key    = 8'h00;

		case (ph)
			PH_HDR0: begin
				fin_d    = in_byte[7];
				opcode_d = in_byte[3:0];
				masked_d = 1'b0;
				len_d    = '0;
				rem_d    = '0;
				key_d    = '0;
				pos_d    = 2'd0;
				cnt_d    = 3'd0;
				htot_d   = 4'd1;
				phase_d  = PH_HDR1;
			end
			PH_HDR1: begin
				masked_d = hdr_mask;
				if (len_code == wsfd_pkg::LEN_CODE_16 || len_code == wsfd_pkg::LEN_CODE_64) begin
					ext8_d  = (len_code == wsfd_pkg::LEN_CODE_64);
					htot_d  = (hdr_mask ? 4'd6 : 4'd2) + (ext8_d ? 4'd8 : 4'd2);
					len_d   = '0;
					cnt_d   = 3'd0;
					phase_d = PH_EXT;
				end else begin
					htot_d   = hdr_mask ? 4'd6 : 4'd2;
					len_d    = LENGTH_BITS'(len_code);
					do_after = 1'b1;
				end
			end
			PH_EXT: begin
				// big-endian shift; the top bytes fall off for narrow lengths
				len_d = {len_q[LENGTH_BITS-9:0], in_byte};
				cnt_d = cnt_q + 3'd1;
				// the 8-byte form wraps the 3-bit count back to zero
				if (cnt_d == (ext8_q ? 3'd0 : 3'd2)) begin
					do_after = 1'b1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], in_byte};
				cnt_d = cnt_q + 3'd1;
				if (cnt_d == 3'd4) begin
					do_hd = 1'b1;
				end
			end
			PH_DATA: begin
				if (masked_q) begin
					case (pos_q)
						2'd0:    e_key = key_q[31:24];
						2'd1:    e_key = key_q[23:16];
						2'd2:    e_key = key_q[15:8];
						default: e_key = key_q[7:0];
					endcase
				end
				pos_d  = pos_q + 2'd1;
				rem_d  = rem_q - LENGTH_BITS'(1);
				e_eof  = (rem_q == LENGTH_BITS'(1));
				e_has  = 1'b1;
				e_data = in_byte;
				emit   = 1'b1;
				if (e_eof) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				phase_d = PH_HDR0;
			end
		endcase

		// length known: masking key next, or header complete
		if (do_after) begin
			cnt_d = 3'd0;
			if (masked_d) begin
				phase_d = PH_KEY;
			end else begin
				do_hd = 1'b1;
			end
		end

		// header complete: payload follows, or the frame is empty
		if (do_hd) begin
			rem_d = len_d;
			pos_d = 2'd0;
			cnt_d = 3'd0;
			if (len_d == '0) begin
				emit    = 1'b1;
				e_eof   = 1'b1;
				phase_d = PH_HDR0;
			end else begin
				phase_d = PH_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			cnt_q    <= 3'd0;
			opcode_q <= 4'd0;
			fin_q    <= 1'b0;
			masked_q <= 1'b0;
			ext8_q   <= 1'b0;
			len_q    <= '0;
			rem_q    <= '0;
			key_q    <= '0;
			pos_q    <= 2'd0;
			htot_q   <= 4'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			opcode_q <= opcode_d;
			fin_q    <= fin_d;
			masked_q <= masked_d;
			ext8_q   <= ext8_d;
			len_q    <= len_d;
			rem_q    <= rem_d;
			key_q    <= key_d;
			pos_q    <= pos_d;
			htot_q   <= htot_d;
		end
	end

	assign q_push         = accept & emit;
	assign q_item.data    = e_data;
	assign q_item.key     = e_key;
	assign q_item.has_byte = e_has;
	assign q_item.eof     = e_eof;
	assign q_item.fin     = fin_d;
	assign q_item.opcode  = opcode_d;
	assign q_item.length  = 64'(len_d);
	assign q_item.hdr_len = htot_d;

	// payload phase is only entered with bytes left to deliver
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (rem_q != '0))
		else $error("payload phase with no bytes remaining");

	// masking key takes four bytes, never more
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_KEY) |-> (cnt_q < 3'd4))
		else $error("masking key byte count overrun");

endmodule

/* rtl/wsfd_queue.sv */
// ----------------------------------------------------------------------------
// wsfd_queue
// Short FIFO of classified items between parser and output stage.
// ----------------------------------------------------------------------------
module wsfd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wsfd_pkg::item_t wr_item,
	output logic            full,
	input  logic            pop,
	output wsfd_pkg::item_t rd_item,
	output logic            empty
);

	wsfd_pkg::item_t mem_q [wsfd_pkg::QUEUE_DEPTH];

	logic [wsfd_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [wsfd_pkg::QUEUE_AW:0]   count_q;
	logic                          do_push, do_pop;

	assign full    = (count_q == (wsfd_pkg::QUEUE_AW+1)'(wsfd_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (wsfd_pkg::QUEUE_AW+1)'(wsfd_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	// fill level tracks pointer distance
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[wsfd_pkg::QUEUE_AW-1:0])
		else $error("queue pointers disagree with count");

endmodule

/* rtl/wsfd_back.sv */
// ----------------------------------------------------------------------------
// wsfd_back
// Output stage: unmasks the payload byte, decodes the opcode flags and holds
// the result item until it is popped.
// ----------------------------------------------------------------------------
module wsfd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  wsfd_pkg::item_t q_item,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output logic [7:0]      out_byte,
	output logic            has_byte,
	output logic            end_of_frame,
	output logic            final_fragment,
	output logic [3:0]      frame_opcode,
	output logic            is_ping,
	output logic            is_close,
	output logic [63:0]     payload_length,
	output logic [3:0]      header_length
);

	logic        valid_q;
	logic [7:0]  byte_q;
	logic        has_q, eof_q, fin_q, ping_q, close_q;
	logic [3:0]  opcode_q, hdr_q;
	logic [63:0] length_q;

	// refill when the slot is free or being drained this cycle
	assign q_pop = ~q_empty & (~valid_q | pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q   <= q_item.data ^ q_item.key;
			has_q    <= q_item.has_byte;
			eof_q    <= q_item.eof;
			fin_q    <= q_item.fin;
			opcode_q <= q_item.opcode;
			ping_q   <= (q_item.opcode == wsfd_pkg::OP_PING);
			close_q  <= (q_item.opcode == wsfd_pkg::OP_CLOSE);
			length_q <= q_item.length;
			hdr_q    <= q_item.hdr_len;
		end
	end

	assign empty          = ~valid_q;
	assign out_byte       = byte_q;
	assign has_byte       = has_q;
	assign end_of_frame   = eof_q;
	assign final_fragment = fin_q;
	assign frame_opcode   = opcode_q;
	assign is_ping        = ping_q;
	assign is_close       = close_q;
	assign payload_length = length_q;
	assign header_length  = hdr_q;

endmodule

/* rtl/websocket_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Path: a payload byte (or the last header byte of an empty frame) enters the
//   item queue at the edge that accepts it and goes on to the result register.
// Throughput: one byte per cycle sustained; header bytes give no result.
//   The parser stalls only when the 4-entry item queue fills up.
// Reset (arst_n low): parser back to the first header byte, queue and result
//   register emptied.
// ----------------------------------------------------------------------------
// RFC 6455 receive-side frame parser. Bytes of back-to-back frames come in on
// a queue-style port (push/full). The front parser decodes FIN and opcode, the
// mask bit and 7-bit length code, a 2- or 8-byte big-endian extended length
// and an optional 4-byte masking key, then tags every payload byte with its
// key byte. A frame of zero length gives a single item without data.
// Items pass a short FIFO to the output stage, which XORs out the mask, flags
// ping and close, and presents the oldest item on a queue-style port
// (empty/pop). The two halves stall independently.
// The queue is written at the accepting edge; the output stage loads its
// result register from the queue once that register is free or being popped.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core #(
	// width kept for the decoded payload length (16..64)
	parameter int LENGTH_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input item side
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        restart,
	// result item side
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        has_byte,
	output logic        end_of_frame,
	output logic        final_fragment,
	output logic [3:0]  frame_opcode,
	output logic        is_ping,
	output logic        is_close,
	output logic [63:0] payload_length,
	output logic [3:0]  header_length
);

	// parser -> queue
	logic            fq_push;
	logic            fq_full;
	wsfd_pkg::item_t fq_item;

	// queue -> output stage
	logic            bq_pop;
	logic            bq_empty;
	wsfd_pkg::item_t bq_item;

	// the input side only waits on queue space
	assign full = fq_full;

	// front: header parsing and byte classification
	wsfd_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_byte (in_byte),
		.restart (restart),
		.q_full  (fq_full),
		.q_push  (fq_push),
		.q_item  (fq_item)
	);

	// decoupling queue
	wsfd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fq_push),
		.wr_item (fq_item),
		.full    (fq_full),
		.pop     (bq_pop),
		.rd_item (bq_item),
		.empty   (bq_empty)
	);

	// back: unmask, flag decode, result register
	wsfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (bq_empty),
		.q_item         (bq_item),
		.q_pop          (bq_pop),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.has_byte       (has_byte),
		.end_of_frame   (end_of_frame),
		.final_fragment (final_fragment),
		.frame_opcode   (frame_opcode),
		.is_ping        (is_ping),
		.is_close       (is_close),
		.payload_length (payload_length),
		.header_length  (header_length)
	);

endmodule
